// ----- rtl/byte_ring_fifo_multi_lane_top_assert.svh -----
// Assertion macros for the byte ring FIFO checker.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef BYTE_RING_FIFO_MULTI_LANE_TOP_ASSERT_SVH
`define BYTE_RING_FIFO_MULTI_LANE_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BRF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("byte ring fifo check failed");

// next-cycle implication, checked out of reset
`define BRF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("byte ring fifo check failed");

`endif

// ----- rtl/brf_pkg.sv -----
// Shared types and codes for the byte ring FIFO.
// No dependencies; used by the top, brf_ctrl, brf_merge and brf_checker.
package brf_pkg;

    localparam int CMD_W    = 3;
    localparam int LEN_W    = 13;
    localparam int DATA_W   = 64;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 13;

    localparam logic [CMD_W-1:0] CMD_ENQUEUE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DEQUEUE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SKIP    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SHORT    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [LEN_W-1:0]  length;
        logic [DATA_W-1:0] write_data;
    } req_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CNT_W-1:0]    done_count;
        logic [DATA_W-1:0]   read_data;
        logic [CNT_W-1:0]    used_bytes;
        logic [CNT_W-1:0]    free_bytes;
        logic [CNT_W-1:0]    contiguous_write;
        logic [CNT_W-1:0]    contiguous_read;
    } rsp_item_t;

    // finished command handed from the sequencer to the merge stage
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CNT_W-1:0]    done_count;
        logic                is_read;
        logic [CNT_W-1:0]    used_bytes;
        logic [CNT_W-1:0]    free_bytes;
        logic [CNT_W-1:0]    contiguous_write;
        logic [CNT_W-1:0]    contiguous_read;
    } post_t;

endpackage

// ----- rtl/brf_stream_if.sv -----
// Valid/ready channel carrying one item of payload type T.
// No dependencies; the payload type is set where the channel is instantiated.
interface brf_stream_if #(parameter type T = logic);

    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

// ----- rtl/byte_ring_fifo_multi_lane_top.sv -----
// Byte ring FIFO with multi-lane reads: top level.
// Depends on brf_pkg, brf_stream_if, brf_ctrl, brf_lane and brf_merge.
//
//   channel  dir  payload               handshake
//   req      in   brf_pkg::req_item_t   valid/ready, one command per item
//   rsp      out  brf_pkg::rsp_item_t   valid/ready, one result per item
//
// One item is taken at a time. Clear, skip, refused and zero-length commands go
// straight to S_POST, dequeue and peek pass S_READ first, an enqueue S_WRITE:
// each lane copy has a single write port, so stored bytes go in one per cycle.
// A finished result waits in the output register while the next item is taken.
// Reset empties the ring at once; stored bytes are undefined until written.
module byte_ring_fifo_multi_lane_top #(
    parameter int CAPACITY = 4096,
    parameter int LANES    = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    brf_stream_if.sink   req,
    brf_stream_if.source rsp
);

    localparam int IW = $clog2(CAPACITY);

    brf_pkg::post_t        post;
    logic                  post_valid;
    logic                  post_ready;
    logic                  wr_en;
    logic [IW-1:0]         wr_addr;
    logic [7:0]            wr_byte;
    logic                  rd_en;
    logic [IW-1:0]         rd_base;
    logic [LANES-1:0][7:0] lane_bytes;

    brf_ctrl #(
        .CAPACITY (CAPACITY),
        .LANES    (LANES)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .post       (post),
        .post_valid (post_valid),
        .post_ready (post_ready),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_byte    (wr_byte),
        .rd_en      (rd_en),
        .rd_base    (rd_base)
    );

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        brf_lane #(
            .CAPACITY (CAPACITY),
            .LANE_ID  (g)
        ) u_lane (
            .clk     (clk),
            .wr_en   (wr_en),
            .wr_addr (wr_addr),
            .wr_byte (wr_byte),
            .rd_en   (rd_en),
            .rd_base (rd_base),
            .rd_byte (lane_bytes[g])
        );
    end

    brf_merge #(
        .LANES (LANES)
    ) u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .post       (post),
        .post_valid (post_valid),
        .post_ready (post_ready),
        .lane_bytes (lane_bytes),
        .rsp        (rsp)
    );

endmodule

// ----- rtl/brf_lane.sv -----
// One lane of the byte store: a full copy of the ring with a registered read.
// Reads the byte at its own offset from the shared read base. Uses nothing else.
module brf_lane #(
    parameter int CAPACITY = 4096,
    parameter int LANE_ID  = 0
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [$clog2(CAPACITY)-1:0] wr_addr,
    input  logic [7:0]                  wr_byte,
    input  logic                        rd_en,
    input  logic [$clog2(CAPACITY)-1:0] rd_base,
    output logic [7:0]                  rd_byte
);

    localparam int IW = $clog2(CAPACITY);

    logic [7:0]    mem [CAPACITY];
    logic [7:0]    rd_byte_reg;
    logic [IW:0]   rd_sum;
    logic [IW-1:0] rd_addr;

    // wrap the lane offset at the capacity
    always_comb
    begin
        rd_sum = (IW+1)'(rd_base) + (IW+1)'(LANE_ID);
        if (rd_sum >= (IW+1)'(CAPACITY))
        begin
            rd_sum = rd_sum - (IW+1)'(CAPACITY);
        end
        rd_addr = rd_sum[IW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_byte;
        end
        if (rd_en)
        begin
            rd_byte_reg <= mem[rd_addr];
        end
    end

    assign rd_byte = rd_byte_reg;

endmodule

// ----- rtl/brf_ctrl.sv -----
// Command sequencer: pointers, used count, acceptance checks and byte writes.
// Depends on brf_pkg and brf_stream_if; drives the lanes and the merge stage.
module brf_ctrl #(
    parameter int CAPACITY = 4096,
    parameter int LANES    = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    brf_stream_if.sink                  req,
    output brf_pkg::post_t              post,
    output logic                        post_valid,
    input  logic                        post_ready,
    output logic                        wr_en,
    output logic [$clog2(CAPACITY)-1:0] wr_addr,
    output logic [7:0]                  wr_byte,
    output logic                        rd_en,
    output logic [$clog2(CAPACITY)-1:0] rd_base
);

    localparam int IW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int SW   = CW + 1;
    localparam int CMPW = (CW > brf_pkg::LEN_W) ? CW : brf_pkg::LEN_W;
    localparam int WCW  = $clog2(LANES + 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_WRITE = 4'b0010,
        S_READ  = 4'b0100,
        S_POST  = 4'b1000
    } state_t;

    state_t                       state_reg, state_next;
    logic [IW-1:0]                rd_idx_reg, rd_idx_next;
    logic [IW-1:0]                wr_idx_reg, wr_idx_next;
    logic [CW-1:0]                used_reg, used_next;
    logic [IW-1:0]                waddr_reg, waddr_next;
    logic [IW-1:0]                rbase_reg, rbase_next;
    logic [brf_pkg::DATA_W-1:0]   wbytes_reg, wbytes_next;
    logic [WCW-1:0]               wcnt_reg, wcnt_next;
    logic [brf_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [brf_pkg::CNT_W-1:0]    done_reg, done_next;
    logic                         is_read_reg, is_read_next;

    logic [brf_pkg::CMD_W-1:0]    cmd;
    logic [brf_pkg::LEN_W-1:0]    len;
    logic [CMPW-1:0]              len_c;
    logic [CMPW-1:0]              used_c;
    logic [CMPW-1:0]              free_c;
    logic [CW-1:0]                free_w;
    logic                         too_long;
    logic [SW-1:0]                rd_sum;
    logic [SW-1:0]                wr_sum;
    logic [IW-1:0]                rd_adv;
    logic [IW-1:0]                wr_adv;
    logic [IW-1:0]                waddr_inc;
    logic [CW-1:0]                run_w;
    logic [CW-1:0]                run_r;

    assign cmd    = req.payload.command;
    assign len    = req.payload.length;
    assign free_w = CW'(CAPACITY) - used_reg;
    assign len_c  = CMPW'(len);
    assign used_c = CMPW'(used_reg);
    assign free_c = CMPW'(free_w);

    assign too_long = (cmd inside {brf_pkg::CMD_ENQUEUE, brf_pkg::CMD_DEQUEUE,
                                   brf_pkg::CMD_PEEK}) && (len_c > CMPW'(LANES));

    // pointer advance by the command length, one wrap at most
    always_comb
    begin
        rd_sum = SW'(rd_idx_reg) + SW'(len);
        if (rd_sum >= SW'(CAPACITY))
        begin
            rd_sum = rd_sum - SW'(CAPACITY);
        end
        wr_sum = SW'(wr_idx_reg) + SW'(len);
        if (wr_sum >= SW'(CAPACITY))
        begin
            wr_sum = wr_sum - SW'(CAPACITY);
        end
        rd_adv = rd_sum[IW-1:0];
        wr_adv = wr_sum[IW-1:0];
    end

    assign waddr_inc = (waddr_reg == IW'(CAPACITY - 1)) ? '0 : waddr_reg + IW'(1);

    always_comb
    begin
        state_next   = state_reg;
        rd_idx_next  = rd_idx_reg;
        wr_idx_next  = wr_idx_reg;
        used_next    = used_reg;
        waddr_next   = waddr_reg;
        rbase_next   = rbase_reg;
        wbytes_next  = wbytes_reg;
        wcnt_next    = wcnt_reg;
        status_next  = status_reg;
        done_next    = done_reg;
        is_read_next = is_read_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    waddr_next   = wr_idx_reg;
                    rbase_next   = rd_idx_reg;
                    wbytes_next  = req.payload.write_data;
                    wcnt_next    = WCW'(len);
                    status_next  = brf_pkg::ST_DONE;
                    done_next    = '0;
                    is_read_next = 1'b0;
                    state_next   = S_POST;
                    if (too_long)
                    begin
                        status_next = brf_pkg::ST_TOO_LONG;
                    end
                    else
                    begin
                        case (cmd)
                            brf_pkg::CMD_ENQUEUE:
                            begin
                                if (len_c > free_c)
                                begin
                                    status_next = brf_pkg::ST_SHORT;
                                end
                                else
                                begin
                                    wr_idx_next = wr_adv;
                                    used_next   = used_reg + CW'(len);
                                    done_next   = len;
                                    if (len != '0)
                                    begin
                                        state_next = S_WRITE;
                                    end
                                end
                            end
                            brf_pkg::CMD_DEQUEUE, brf_pkg::CMD_PEEK:
                            begin
                                if (len_c > used_c)
                                begin
                                    status_next = brf_pkg::ST_SHORT;
                                end
                                else
                                begin
                                    done_next    = len;
                                    is_read_next = 1'b1;
                                    if (cmd == brf_pkg::CMD_DEQUEUE)
                                    begin
                                        rd_idx_next = rd_adv;
                                        used_next   = used_reg - CW'(len);
                                    end
                                    if (len != '0)
                                    begin
                                        state_next = S_READ;
                                    end
                                end
                            end
                            brf_pkg::CMD_SKIP:
                            begin
                                if (len_c > used_c)
                                begin
                                    status_next = brf_pkg::ST_SHORT;
                                end
                                else
                                begin
                                    rd_idx_next = rd_adv;
                                    used_next   = used_reg - CW'(len);
                                    done_next   = len;
                                end
                            end
                            brf_pkg::CMD_CLEAR:
                            begin
                                rd_idx_next = '0;
                                wr_idx_next = '0;
                                used_next   = '0;
                            end
                            default:
                            begin
                                // unknown command: report state, change nothing
                            end
                        endcase
                    end
                end
            end
            S_WRITE:
            begin
                // one byte per cycle into every lane copy
                waddr_next  = waddr_inc;
                wbytes_next = wbytes_reg >> 8;
                wcnt_next   = wcnt_reg - WCW'(1);
                if (wcnt_reg == WCW'(1))
                begin
                    state_next = S_POST;
                end
            end
            S_READ:
            begin
                state_next = S_POST;
            end
            S_POST:
            begin
                if (post_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            rd_idx_reg <= '0;
            wr_idx_reg <= '0;
            used_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_idx_reg <= rd_idx_next;
            wr_idx_reg <= wr_idx_next;
            used_reg   <= used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        waddr_reg   <= waddr_next;
        rbase_reg   <= rbase_next;
        wbytes_reg  <= wbytes_next;
        wcnt_reg    <= wcnt_next;
        status_reg  <= status_next;
        done_reg    <= done_next;
        is_read_reg <= is_read_next;
    end

    // contiguous runs up to the wrap point or the other pointer
    always_comb
    begin
        if (used_reg >= CW'(CAPACITY))
        begin
            run_w = '0;
        end
        else if (rd_idx_reg > wr_idx_reg)
        begin
            run_w = CW'(rd_idx_reg - wr_idx_reg);
        end
        else
        begin
            run_w = CW'(CAPACITY) - CW'(wr_idx_reg);
        end

        if (used_reg == '0)
        begin
            run_r = '0;
        end
        else if (wr_idx_reg > rd_idx_reg)
        begin
            run_r = CW'(wr_idx_reg - rd_idx_reg);
        end
        else
        begin
            run_r = CW'(CAPACITY) - CW'(rd_idx_reg);
        end
    end

    assign req.ready  = (state_reg == S_IDLE);
    assign post_valid = (state_reg == S_POST);

    assign post.status           = status_reg;
    assign post.done_count       = done_reg;
    assign post.is_read          = is_read_reg;
    assign post.used_bytes       = brf_pkg::CNT_W'(used_reg);
    assign post.free_bytes       = brf_pkg::CNT_W'(free_w);
    assign post.contiguous_write = brf_pkg::CNT_W'(run_w);
    assign post.contiguous_read  = brf_pkg::CNT_W'(run_r);

    assign wr_en   = (state_reg == S_WRITE);
    assign wr_addr = waddr_reg;
    assign wr_byte = wbytes_reg[7:0];
    assign rd_en   = (state_reg == S_READ);
    assign rd_base = rbase_reg;

endmodule

// ----- rtl/brf_merge.sv -----
// Merge stage: gathers the lane bytes into read_data and holds the result item.
// Depends on brf_pkg and brf_stream_if.
module brf_merge #(
    parameter int LANES = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  brf_pkg::post_t        post,
    input  logic                  post_valid,
    output logic                  post_ready,
    input  logic [LANES-1:0][7:0] lane_bytes,
    brf_stream_if.source          rsp
);

    logic                       valid_reg;
    brf_pkg::rsp_item_t         item_reg;
    logic [brf_pkg::DATA_W-1:0] read_data;

    // lanes at and above the byte count stay zero
    always_comb
    begin
        read_data = '0;
        for (int k = 0; k < LANES; k++)
        begin
            if (post.is_read && (brf_pkg::CNT_W'(k) < post.done_count))
            begin
                read_data[8*k +: 8] = lane_bytes[k];
            end
        end
    end

    assign post_ready = !valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (post_ready)
        begin
            valid_reg <= post_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (post_ready && post_valid)
        begin
            item_reg.status           <= post.status;
            item_reg.done_count       <= post.done_count;
            item_reg.read_data        <= read_data;
            item_reg.used_bytes       <= post.used_bytes;
            item_reg.free_bytes       <= post.free_bytes;
            item_reg.contiguous_write <= post.contiguous_write;
            item_reg.contiguous_read  <= post.contiguous_read;
        end
    end

    assign rsp.valid   = valid_reg;
    assign rsp.payload = item_reg;

endmodule

// ----- rtl/brf_checker.sv -----
// Port-level checks for the byte ring FIFO, bound to the top level.
// Depends on brf_pkg and the assertion macros header.
`include "byte_ring_fifo_multi_lane_top_assert.svh"

module brf_checker #(
    parameter int CAPACITY = 4096
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_ready,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic [brf_pkg::STATUS_W-1:0] rsp_status,
    input logic [brf_pkg::CNT_W-1:0]    rsp_done_count,
    input logic [brf_pkg::CNT_W-1:0]    rsp_used_bytes,
    input logic [brf_pkg::CNT_W-1:0]    rsp_free_bytes
);

    // used and free always make up the capacity
    `BRF_ASSERT_NOW(a_used_free_sum, rsp_valid, brf_pkg::CNT_W'(rsp_used_bytes + rsp_free_bytes) == brf_pkg::CNT_W'(CAPACITY))

    // a refused command moves nothing
    `BRF_ASSERT_NOW(a_refused_zero, rsp_valid && (rsp_status != brf_pkg::ST_DONE), rsp_done_count == '0)

    // one command in flight: no item taken in the cycle after one is taken
    `BRF_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready)

    // a stalled result holds
    `BRF_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_done_count) && $stable(rsp_used_bytes))

endmodule

bind byte_ring_fifo_multi_lane_top brf_checker #(
    .CAPACITY (CAPACITY)
) u_brf_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_status     (rsp.payload.status),
    .rsp_done_count (rsp.payload.done_count),
    .rsp_used_bytes (rsp.payload.used_bytes),
    .rsp_free_bytes (rsp.payload.free_bytes)
);
